// ===== rtl/regex_syntax_prechecker_top_macros.svh =====
// assertion macros used by the checker file
`ifndef REGEX_SYNTAX_PRECHECKER_TOP_MACROS_SVH
`define REGEX_SYNTAX_PRECHECKER_TOP_MACROS_SVH

// property checked only outside reset
`define RSP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rsp assertion failed");

// property checked at every edge, reset included
`define RSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rsp assertion failed");

`endif

// ===== rtl/rsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsp_pkg
// shared types and constants of the regex syntax prechecker
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int CHAR_W    = 8;
  localparam int LEN_W     = 12;
  localparam int COUNT_W   = 13;
  localparam int LIMIT_W   = 4;
  localparam int DEPTH_W   = 5;
  localparam int CAUSE_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;
  localparam int CLS_W     = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROUND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SQUARE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CURLY  = 2'd3;

  localparam logic [LEN_W-1:0]   RST_MAX_LENGTH = 12'd256;
  localparam logic [LIMIT_W-1:0] RST_MAX_DEPTH  = 4'd8;

  // error causes
  localparam logic [CAUSE_W-1:0] ERR_NONE         = 4'd0;
  localparam logic [CAUSE_W-1:0] ERR_BAD_CHAR     = 4'd1;
  localparam logic [CAUSE_W-1:0] ERR_DEEP_ROUND   = 4'd2;
  localparam logic [CAUSE_W-1:0] ERR_DEEP_SQUARE  = 4'd3;
  localparam logic [CAUSE_W-1:0] ERR_DEEP_CURLY   = 4'd4;
  localparam logic [CAUSE_W-1:0] ERR_CLOSE_ROUND  = 4'd5;
  localparam logic [CAUSE_W-1:0] ERR_CLOSE_SQUARE = 4'd6;
  localparam logic [CAUSE_W-1:0] ERR_CLOSE_CURLY  = 4'd7;
  localparam logic [CAUSE_W-1:0] ERR_LEADING_OP   = 4'd8;
  localparam logic [CAUSE_W-1:0] ERR_CONSEC_OPS   = 4'd9;
  localparam logic [CAUSE_W-1:0] ERR_TOO_LONG     = 4'd10;
  localparam logic [CAUSE_W-1:0] ERR_UNBALANCED   = 4'd11;

  // character classes
  localparam logic [CLS_W-1:0] CLS_PLAIN        = 4'd0;
  localparam logic [CLS_W-1:0] CLS_BAD          = 4'd1;
  localparam logic [CLS_W-1:0] CLS_OPEN_ROUND   = 4'd2;
  localparam logic [CLS_W-1:0] CLS_OPEN_SQUARE  = 4'd3;
  localparam logic [CLS_W-1:0] CLS_OPEN_CURLY   = 4'd4;
  localparam logic [CLS_W-1:0] CLS_CLOSE_ROUND  = 4'd5;
  localparam logic [CLS_W-1:0] CLS_CLOSE_SQUARE = 4'd6;
  localparam logic [CLS_W-1:0] CLS_CLOSE_CURLY  = 4'd7;
  localparam logic [CLS_W-1:0] CLS_OP           = 4'd8;
  localparam logic [CLS_W-1:0] CLS_QMARK        = 4'd9;

  // character codes
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic             last;
  } rsp_item_t;

  typedef struct packed {
    logic      push;
    rsp_item_t item;
  } rsp_push_t;

endpackage

// ===== rtl/rsp_ifs.sv =====
// ----------------------------------------------------------------------------
// rsp channel interfaces
// character, verdict and register write channels
// ----------------------------------------------------------------------------
interface rsp_char_if import rsp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink (input valid, char_code, last_char, output ready);
endinterface

interface rsp_verdict_if import rsp_pkg::*;;
  logic               valid;
  logic               ready;
  logic               expr_valid;
  logic [CAUSE_W-1:0] error_cause;

  modport source (output valid, expr_valid, error_cause, input ready);
  modport sink (input valid, expr_valid, error_cause, output ready);
endinterface

interface rsp_cfg_if import rsp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/rsp_front.sv =====
// ----------------------------------------------------------------------------
// rsp_front
// accepts characters and classifies them for the checking stage
// ----------------------------------------------------------------------------
module rsp_front import rsp_pkg::*; (
  rsp_char_if.sink         chars,
  input  logic             q_ready,
  output rsp_push_t        q_push
);

  function automatic logic [CLS_W-1:0] classify(input logic [CHAR_W-1:0] c);
    logic [CLS_W-1:0] cls;
    cls = CLS_BAD;
    if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A)) begin
      cls = CLS_PLAIN;
    end else begin
      case (c) inside
        CH_DOT, CH_UNDER, CH_DASH, CH_CARET, CH_DOLLAR, CH_SPACE, CH_BSLASH:
          cls = CLS_PLAIN;
        CH_STAR, CH_PLUS: cls = CLS_OP;
        CH_QMARK:  cls = CLS_QMARK;
        CH_LPAREN: cls = CLS_OPEN_ROUND;
        CH_LBRACK: cls = CLS_OPEN_SQUARE;
        CH_LBRACE: cls = CLS_OPEN_CURLY;
        CH_RPAREN: cls = CLS_CLOSE_ROUND;
        CH_RBRACK: cls = CLS_CLOSE_SQUARE;
        CH_RBRACE: cls = CLS_CLOSE_CURLY;
        default:   cls = CLS_BAD;
      endcase
    end
    return cls;
  endfunction

  assign chars.ready      = q_ready;
  assign q_push.push      = chars.valid & q_ready;
  assign q_push.item.cls  = classify(chars.char_code);
  assign q_push.item.last = chars.last_char;

endmodule

// ===== rtl/rsp_queue.sv =====
// ----------------------------------------------------------------------------
// rsp_queue
// short fifo of classified characters between front and back
// ----------------------------------------------------------------------------
module rsp_queue import rsp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  rsp_push_t q_push,
  output logic      q_ready,
  output logic      q_valid,
  output rsp_item_t q_item,
  input  logic      q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  rsp_item_t        mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_ready = (count != CNT_FULL);
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem[wr_ptr] <= q_push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (q_push.push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!q_push.push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rsp_back.sv =====
// ----------------------------------------------------------------------------
// rsp_back
// tracks length, depths and first error; registers the verdict
// ----------------------------------------------------------------------------
module rsp_back import rsp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  rsp_item_t        q_item,
  output logic             q_pop,
  rsp_cfg_if.sink          cfg,
  rsp_verdict_if.source    verdict
);

  logic [LEN_W-1:0]   max_length;
  logic [LIMIT_W-1:0] max_round;
  logic [LIMIT_W-1:0] max_square;
  logic [LIMIT_W-1:0] max_curly;

  logic [COUNT_W-1:0] char_count;
  logic [DEPTH_W-1:0] round_depth;
  logic [DEPTH_W-1:0] square_depth;
  logic [DEPTH_W-1:0] curly_depth;
  logic               prev_op;
  logic               prev_qmark;
  logic [CAUSE_W-1:0] first_error;

  logic [COUNT_W-1:0] char_count_next;
  logic [DEPTH_W-1:0] round_depth_next;
  logic [DEPTH_W-1:0] square_depth_next;
  logic [DEPTH_W-1:0] curly_depth_next;
  logic [CAUSE_W-1:0] first_error_next;
  logic [CAUSE_W-1:0] cause;
  logic               out_valid;
  logic               out_expr_valid;
  logic [CAUSE_W-1:0] out_cause;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= RST_MAX_LENGTH;
      max_round  <= RST_MAX_DEPTH;
      max_square <= RST_MAX_DEPTH;
      max_curly  <= RST_MAX_DEPTH;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MAX_LENGTH: max_length <= cfg.data[LEN_W-1:0];
        REG_MAX_ROUND:  max_round  <= cfg.data[LIMIT_W-1:0];
        REG_MAX_SQUARE: max_square <= cfg.data[LIMIT_W-1:0];
        REG_MAX_CURLY:  max_curly  <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // a last character waits while an undelivered verdict blocks the register
  assign q_pop = q_valid & (~q_item.last | ~out_valid | verdict.ready);

  always_comb begin
    round_depth_next  = round_depth;
    square_depth_next = square_depth;
    curly_depth_next  = curly_depth;
    first_error_next  = first_error;
    char_count_next   = char_count;
    if (char_count <= {1'b0, max_length}) begin
      char_count_next = char_count + 1'b1;
    end
    // once an error is seen the depths freeze
    if (first_error == ERR_NONE) begin
      unique case (q_item.cls) inside
        CLS_BAD: first_error_next = ERR_BAD_CHAR;
        CLS_OPEN_ROUND: begin
          round_depth_next = round_depth + 1'b1;
          if (round_depth_next > {1'b0, max_round}) first_error_next = ERR_DEEP_ROUND;
        end
        CLS_OPEN_SQUARE: begin
          square_depth_next = square_depth + 1'b1;
          if (square_depth_next > {1'b0, max_square}) first_error_next = ERR_DEEP_SQUARE;
        end
        CLS_OPEN_CURLY: begin
          curly_depth_next = curly_depth + 1'b1;
          if (curly_depth_next > {1'b0, max_curly}) first_error_next = ERR_DEEP_CURLY;
        end
        CLS_CLOSE_ROUND: begin
          if (round_depth == '0) first_error_next = ERR_CLOSE_ROUND;
          else round_depth_next = round_depth - 1'b1;
        end
        CLS_CLOSE_SQUARE: begin
          if (square_depth == '0) first_error_next = ERR_CLOSE_SQUARE;
          else square_depth_next = square_depth - 1'b1;
        end
        CLS_CLOSE_CURLY: begin
          if (curly_depth == '0) first_error_next = ERR_CLOSE_CURLY;
          else curly_depth_next = curly_depth - 1'b1;
        end
        CLS_OP, CLS_QMARK: begin
          if (char_count == '0) begin
            first_error_next = ERR_LEADING_OP;
          end else if (prev_op && !(prev_qmark && q_item.cls == CLS_QMARK)) begin
            first_error_next = ERR_CONSEC_OPS;
          end
        end
        default: ;
      endcase
    end
    if (char_count_next > {1'b0, max_length}) begin
      cause = ERR_TOO_LONG;
    end else if (first_error_next != ERR_NONE) begin
      cause = first_error_next;
    end else if (round_depth_next != '0 || square_depth_next != '0 ||
                 curly_depth_next != '0) begin
      cause = ERR_UNBALANCED;
    end else begin
      cause = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count   <= '0;
      round_depth  <= '0;
      square_depth <= '0;
      curly_depth  <= '0;
      prev_op      <= 1'b0;
      prev_qmark   <= 1'b0;
      first_error  <= ERR_NONE;
    end else if (q_pop) begin
      if (q_item.last) begin
        char_count   <= '0;
        round_depth  <= '0;
        square_depth <= '0;
        curly_depth  <= '0;
        prev_op      <= 1'b0;
        prev_qmark   <= 1'b0;
        first_error  <= ERR_NONE;
      end else begin
        char_count   <= char_count_next;
        round_depth  <= round_depth_next;
        square_depth <= square_depth_next;
        curly_depth  <= curly_depth_next;
        prev_op      <= (q_item.cls == CLS_OP) || (q_item.cls == CLS_QMARK);
        prev_qmark   <= (q_item.cls == CLS_QMARK);
        first_error  <= first_error_next;
      end
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_item.last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      out_expr_valid <= (cause == ERR_NONE);
      out_cause      <= cause;
    end
  end

  assign verdict.valid       = out_valid;
  assign verdict.expr_valid  = out_expr_valid;
  assign verdict.error_cause = out_cause;

endmodule

// ===== rtl/regex_syntax_prechecker_top.sv =====
// ----------------------------------------------------------------------------
// regex_syntax_prechecker_top
// syntax precheck of a regular expression streamed one character a request
// ----------------------------------------------------------------------------
// chars: one character per request, last_char set on the final one.
// verdict: one request per expression with expr_valid and error_cause.
// cfg: register writes (length limit and three bracket depth limits),
//   always ready; write only while no expression is in flight.
// throughput: one character per cycle while the queue has room; the back end
//   updates its counters and depths for one character each cycle unless a
//   last character waits on an undelivered verdict. the last character is
//   queued, then the check stage pops it and registers the verdict.
// the queue between classifier and check stage holds QUEUE_DEPTH entries;
//   a verdict register lets the next expression stream in while a verdict
//   waits, and only a further last character waits for it to be taken.
// reset: limits return to 256 and 8/8/8, the queue empties and the
//   running expression state clears.
// ----------------------------------------------------------------------------
module regex_syntax_prechecker_top import rsp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  rsp_char_if.sink      chars,
  rsp_verdict_if.source verdict,
  rsp_cfg_if.sink       cfg
);

  rsp_push_t q_push;
  logic      q_ready;
  logic      q_valid;
  rsp_item_t q_item;
  logic      q_pop;

  rsp_front u_front (
    .chars   (chars),
    .q_ready (q_ready),
    .q_push  (q_push)
  );

  rsp_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  rsp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .verdict (verdict)
  );

endmodule

// ===== rtl/rsp_checker.sv =====
// ----------------------------------------------------------------------------
// rsp_checker
// port level checks of the prechecker, bound to the top level
// ----------------------------------------------------------------------------
`include "regex_syntax_prechecker_top_macros.svh"

module rsp_checker import rsp_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_expr_valid,
  input logic [CAUSE_W-1:0] out_cause,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  // a stalled verdict holds
  `RSP_ASSERT(a_verdict_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_cause))

  // flag agrees with the cause
  `RSP_ASSERT(a_flag_matches_cause, clk, rst, out_valid |-> (out_expr_valid == (out_cause == ERR_NONE)))

  // no verdict right after reset
  `RSP_ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) |-> !out_valid)

  // register writes never stall
  `RSP_ASSERT(a_cfg_ready, clk, rst, cfg_valid |-> cfg_ready)

endmodule

bind regex_syntax_prechecker_top rsp_checker u_rsp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (verdict.valid),
  .out_ready      (verdict.ready),
  .out_expr_valid (verdict.expr_valid),
  .out_cause      (verdict.error_cause),
  .cfg_valid      (cfg.valid),
  .cfg_ready      (cfg.ready)
);

// ===== bench/regex_syntax_prechecker_top_tb.sv =====
// ----------------------------------------------------------------------------
// regex_syntax_prechecker_top_tb
// streams expressions into the prechecker and checks every verdict against a
// behavioral predictor; a directed table covers the extremes and error causes,
// then random well-formed, broken and noise expressions run under several
// limit settings with random stalls on both channels, except in the last two
// phases
module regex_syntax_prechecker_top_tb;
  import rsp_pkg::*;

  typedef struct packed {
    logic               ok;
    logic [CAUSE_W-1:0] cause;
  } verdict_t;

  typedef enum logic {ROW_CHAR, ROW_LIMITS} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [CHAR_W-1:0]   code;
    logic                last;
    logic                typed;
    verdict_t            v;
    logic [LEN_W-1:0]    len;
    logic [LIMIT_W-1:0]  rnd;
    logic [LIMIT_W-1:0]  sqr;
    logic [LIMIT_W-1:0]  crl;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rsp_char_if    chars_if ();
  rsp_verdict_if verdict_if ();
  rsp_cfg_if     cfg_if ();

  regex_syntax_prechecker_top u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .verdict (verdict_if),
    .cfg     (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor limits and running expression state
  logic [LEN_W-1:0]   lim_len    = RST_MAX_LENGTH;
  logic [LIMIT_W-1:0] lim_round  = RST_MAX_DEPTH;
  logic [LIMIT_W-1:0] lim_square = RST_MAX_DEPTH;
  logic [LIMIT_W-1:0] lim_curly  = RST_MAX_DEPTH;
  logic [COUNT_W-1:0] p_len      = '0;
  logic [DEPTH_W-1:0] p_round    = '0;
  logic [DEPTH_W-1:0] p_square   = '0;
  logic [DEPTH_W-1:0] p_curly    = '0;
  logic [CHAR_W-1:0]  p_prev     = '0;
  logic [CAUSE_W-1:0] p_err      = ERR_NONE;

  verdict_t          pending_verdicts[$];
  logic [CHAR_W-1:0] expr_q[$];
  dir_row_t          dir_rows[$];

  int send_idle_pct = 15;
  int recv_idle_pct = 82;
  int sent_chars    = 0;
  int sent_exprs    = 0;
  int checked       = 0;
  int judged_ok     = 0;
  int mismatches    = 0;
  int limit_sets    = 0;

  function automatic bit is_quant(logic [CHAR_W-1:0] c);
    return c == CH_STAR || c == CH_PLUS || c == CH_QMARK;
  endfunction

  function automatic bit is_legal(logic [CHAR_W-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 1'b1;
    if (c >= 8'h41 && c <= 8'h5A) return 1'b1;
    if (c >= 8'h61 && c <= 8'h7A) return 1'b1;
    case (c) inside
      CH_DOT, CH_UNDER, CH_DASH, CH_CARET, CH_DOLLAR, CH_SPACE, CH_STAR, CH_PLUS,
      CH_QMARK, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE,
      CH_BSLASH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // advances the predictor by one character, returns 1 when a verdict is due
  function automatic bit judge_char(input logic [CHAR_W-1:0] c, input logic last,
                                    output verdict_t v);
    logic [CAUSE_W-1:0] cause;
    v = '0;
    if (p_err == ERR_NONE) begin
      if (!is_legal(c)) begin
        p_err = ERR_BAD_CHAR;
      end else begin
        case (c)
          CH_LPAREN: begin
            p_round = p_round + 1'b1;
            if (p_round > lim_round) p_err = ERR_DEEP_ROUND;
          end
          CH_LBRACK: begin
            p_square = p_square + 1'b1;
            if (p_square > lim_square) p_err = ERR_DEEP_SQUARE;
          end
          CH_LBRACE: begin
            p_curly = p_curly + 1'b1;
            if (p_curly > lim_curly) p_err = ERR_DEEP_CURLY;
          end
          CH_RPAREN: begin
            if (p_round == '0) p_err = ERR_CLOSE_ROUND;
            else p_round = p_round - 1'b1;
          end
          CH_RBRACK: begin
            if (p_square == '0) p_err = ERR_CLOSE_SQUARE;
            else p_square = p_square - 1'b1;
          end
          CH_RBRACE: begin
            if (p_curly == '0) p_err = ERR_CLOSE_CURLY;
            else p_curly = p_curly - 1'b1;
          end
          default: begin
            if (is_quant(c)) begin
              if (p_len == '0) p_err = ERR_LEADING_OP;
              else if (is_quant(p_prev) && !(p_prev == CH_QMARK && c == CH_QMARK))
                p_err = ERR_CONSEC_OPS;
            end
          end
        endcase
      end
    end
    // length saturates one past the limit
    if (p_len <= lim_len) p_len = p_len + 1'b1;
    p_prev = c;
    if (!last) return 1'b0;

    if (p_len > lim_len) cause = ERR_TOO_LONG;
    else if (p_err != ERR_NONE) cause = p_err;
    else if (p_round != '0 || p_square != '0 || p_curly != '0) cause = ERR_UNBALANCED;
    else cause = ERR_NONE;
    v.ok    = (cause == ERR_NONE);
    v.cause = cause;
    p_len    = '0;
    p_round  = '0;
    p_square = '0;
    p_curly  = '0;
    p_prev   = '0;
    p_err    = ERR_NONE;
    return 1'b1;
  endfunction

  function automatic dir_row_t char_row(logic [CHAR_W-1:0] c, logic last);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_CHAR;
    row.code = c;
    row.last = last;
    return row;
  endfunction

  function automatic dir_row_t verdict_row(logic [CHAR_W-1:0] c, logic ok,
                                           logic [CAUSE_W-1:0] cause);
    dir_row_t row;
    row         = char_row(c, 1'b1);
    row.typed   = 1'b1;
    row.v.ok    = ok;
    row.v.cause = cause;
    return row;
  endfunction

  function automatic dir_row_t limits_row(logic [LEN_W-1:0] len, logic [LIMIT_W-1:0] rnd,
                                          logic [LIMIT_W-1:0] sqr, logic [LIMIT_W-1:0] crl);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_LIMITS;
    row.len  = len;
    row.rnd  = rnd;
    row.sqr  = sqr;
    row.crl  = crl;
    return row;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_plain();
    case ($urandom_range(0, 3))
      0: return 8'(8'h61 + $urandom_range(0, 25));
      1: return 8'(8'h41 + $urandom_range(0, 25));
      2: return 8'(8'h30 + $urandom_range(0, 9));
      default: begin
        case ($urandom_range(0, 6))
          0: return CH_DOT;
          1: return CH_UNDER;
          2: return CH_DASH;
          3: return CH_CARET;
          4: return CH_DOLLAR;
          5: return CH_SPACE;
          default: return CH_BSLASH;
        endcase
      end
    endcase
  endfunction

  // kind 0 round, 1 square, 2 curly
  function automatic logic [CHAR_W-1:0] bracket_code(int kind, bit closing);
    case (kind)
      0: return closing ? CH_RPAREN : CH_LPAREN;
      1: return closing ? CH_RBRACK : CH_LBRACK;
      default: return closing ? CH_RBRACE : CH_LBRACE;
    endcase
  endfunction

  // mostly well-formed expressions, the rest broken or plain noise
  function automatic void make_expr();
    logic [CHAR_W-1:0] closers[$];
    logic [CHAR_W-1:0] prev;
    int n;
    int mode;
    int kind;
    expr_q = {};
    if ($urandom_range(0, 3) == 0 && lim_len <= 40)
      n = int'(lim_len) + int'($urandom_range(0, 4)) - 2;
    else
      n = $urandom_range(1, 12);
    if (n < 1) n = 1;
    mode = $urandom_range(0, 99);

    if (mode >= 93) begin
      repeat (n) expr_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if (mode >= 87) begin
      // run of openers to go past the depth limits
      kind = $urandom_range(0, 2);
      repeat ($urandom_range(1, 18)) expr_q.push_back(bracket_code(kind, 1'b0));
      expr_q.push_back(pick_plain());
      return;
    end

    while (expr_q.size() + closers.size() < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: expr_q.push_back(pick_plain());
        5, 6: begin
          if (expr_q.size() == 0) begin
            expr_q.push_back(pick_plain());
          end else begin
            prev = expr_q[$];
            if (prev == CH_QMARK && $urandom_range(0, 1) == 1) expr_q.push_back(CH_QMARK);
            else if (is_quant(prev)) expr_q.push_back(pick_plain());
            else begin
              case ($urandom_range(0, 2))
                0: expr_q.push_back(CH_STAR);
                1: expr_q.push_back(CH_PLUS);
                default: expr_q.push_back(CH_QMARK);
              endcase
            end
          end
        end
        7, 8: begin
          if (closers.size() < 4) begin
            kind = $urandom_range(0, 2);
            expr_q.push_back(bracket_code(kind, 1'b0));
            closers.push_back(bracket_code(kind, 1'b1));
          end else begin
            expr_q.push_back(pick_plain());
          end
        end
        default: begin
          if (closers.size() != 0) expr_q.push_back(closers.pop_back());
          else expr_q.push_back(pick_plain());
        end
      endcase
    end
    while (closers.size() != 0) expr_q.push_back(closers.pop_back());

    if (mode >= 80) begin
      expr_q.insert($urandom_range(0, expr_q.size()),
                    bracket_code($urandom_range(0, 2), $urandom_range(0, 1)));
    end else if (mode >= 70) begin
      expr_q[$urandom_range(0, expr_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] code, input logic last,
                           input logic typed, input verdict_t typed_v);
    verdict_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= code;
    chars_if.last_char <= last;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    sent_chars++;
    if (judge_char(code, last, v)) begin
      sent_exprs++;
      pending_verdicts.push_back(typed ? typed_v : v);
    end
  endtask

  task automatic send_expr();
    foreach (expr_q[i]) send_char(expr_q[i], i == expr_q.size() - 1, 1'b0, '0);
  endtask

  // block is idle once every verdict is out and the pipeline has drained
  task automatic settle();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limits(input logic [LEN_W-1:0] len, input logic [LIMIT_W-1:0] rnd,
                              input logic [LIMIT_W-1:0] sqr, input logic [LIMIT_W-1:0] crl);
    logic [CFG_IDX_W-1:0] order [4];
    order[0] = REG_MAX_LENGTH;
    order[1] = REG_MAX_ROUND;
    order[2] = REG_MAX_SQUARE;
    order[3] = REG_MAX_CURLY;
    for (int k = 0; k < 4; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= order[k];
      // upper data bits of the depth registers carry junk
      case (order[k])
        REG_MAX_LENGTH: cfg_if.data <= len;
        REG_MAX_ROUND:  cfg_if.data <= {8'($urandom_range(0, 255)), rnd};
        REG_MAX_SQUARE: cfg_if.data <= {8'($urandom_range(0, 255)), sqr};
        default:        cfg_if.data <= {8'($urandom_range(0, 255)), crl};
      endcase
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
    end
    cfg_if.valid <= 1'b0;
    lim_len    = len;
    lim_round  = rnd;
    lim_square = sqr;
    lim_curly  = crl;
    limit_sets++;
  endtask

  initial begin
    verdict_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      verdict_if.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && verdict_if.valid && verdict_if.ready) begin
      checked++;
      if (verdict_if.expr_valid === 1'b1) judged_ok++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("verdict %0d arrived with none pending: valid=%0b cause=%0d",
                   checked, verdict_if.expr_valid, verdict_if.error_cause);
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_if.expr_valid !== want.ok || verdict_if.error_cause !== want.cause) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict %0d: expected valid=%0b cause=%0d, got valid=%0b cause=%0d",
                     checked, want.ok, want.cause, verdict_if.expr_valid,
                     verdict_if.error_cause);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("run timed out with %0d verdicts still pending", pending_verdicts.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [LEN_W-1:0]   n_len;
    logic [LIMIT_W-1:0] n_rnd;
    logic [LIMIT_W-1:0] n_sqr;
    logic [LIMIT_W-1:0] n_crl;
    int phase_start;

    chars_if.valid     = 1'b0;
    chars_if.char_code = '0;
    chars_if.last_char = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_MAX_LENGTH;
    cfg_if.data        = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limits: 256 / 8 / 8 / 8
    dir_rows.push_back(verdict_row("a", 1'b1, ERR_NONE));
    dir_rows.push_back(verdict_row(CH_STAR, 1'b0, ERR_LEADING_OP));
    dir_rows.push_back(verdict_row(8'h00, 1'b0, ERR_BAD_CHAR));
    dir_rows.push_back(verdict_row(8'hFF, 1'b0, ERR_BAD_CHAR));
    dir_rows.push_back(verdict_row(CH_RBRACK, 1'b0, ERR_CLOSE_SQUARE));
    dir_rows.push_back(verdict_row(CH_RBRACE, 1'b0, ERR_CLOSE_CURLY));
    dir_rows.push_back(char_row(CH_LBRACK, 1'b0));
    dir_rows.push_back(verdict_row("b", 1'b0, ERR_UNBALANCED));
    // doubled question mark is legal
    dir_rows.push_back(char_row("a", 1'b0));
    dir_rows.push_back(char_row(CH_QMARK, 1'b0));
    dir_rows.push_back(verdict_row(CH_QMARK, 1'b1, ERR_NONE));
    // first error sticks through later characters
    dir_rows.push_back(char_row(CH_RPAREN, 1'b0));
    dir_rows.push_back(char_row(CH_LPAREN, 1'b0));
    dir_rows.push_back(verdict_row(CH_PLUS, 1'b0, ERR_CLOSE_ROUND));
    dir_rows.push_back(char_row("a", 1'b0));
    dir_rows.push_back(char_row(CH_PLUS, 1'b0));
    dir_rows.push_back(verdict_row(CH_STAR, 1'b0, ERR_CONSEC_OPS));
    dir_rows.push_back(limits_row(12'd2, 4'd0, 4'd1, 4'd15));
    dir_rows.push_back(verdict_row(CH_LPAREN, 1'b0, ERR_DEEP_ROUND));
    dir_rows.push_back(char_row(CH_LBRACK, 1'b0));
    dir_rows.push_back(verdict_row(CH_LBRACK, 1'b0, ERR_DEEP_SQUARE));
    dir_rows.push_back(char_row(CH_LBRACE, 1'b0));
    dir_rows.push_back(verdict_row(CH_RBRACE, 1'b1, ERR_NONE));
    // too long wins over the depth error
    dir_rows.push_back(char_row(CH_LPAREN, 1'b0));
    dir_rows.push_back(char_row("a", 1'b0));
    dir_rows.push_back(verdict_row("b", 1'b0, ERR_TOO_LONG));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LIMITS) begin
        chars_if.valid <= 1'b0;
        settle();
        write_limits(dir_rows[i].len, dir_rows[i].rnd, dir_rows[i].sqr, dir_rows[i].crl);
      end else begin
        send_char(dir_rows[i].code, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].v);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin n_len = 12'd256;  n_rnd = 4'd8;  n_sqr = 4'd8;  n_crl = 4'd8;  end
        1: begin n_len = 12'd1;    n_rnd = 4'd0;  n_sqr = 4'd0;  n_crl = 4'd0;  end
        2: begin n_len = 12'd4095; n_rnd = 4'd15; n_sqr = 4'd15; n_crl = 4'd15; end
        3: begin n_len = 12'd0;    n_rnd = 4'd15; n_sqr = 4'd0;  n_crl = 4'd15; end
        4: begin n_len = 12'd20;   n_rnd = 4'd2;  n_sqr = 4'd3;  n_crl = 4'd1;  end
        5: begin n_len = 12'd7;    n_rnd = 4'd1;  n_sqr = 4'd1;  n_crl = 4'd1;  end
        default: begin
          n_len = 12'($urandom_range(1, 40));
          n_rnd = 4'($urandom_range(0, 15));
          n_sqr = 4'($urandom_range(0, 15));
          n_crl = 4'($urandom_range(0, 15));
        end
      endcase
      if (ph == 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 15;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      chars_if.valid <= 1'b0;
      settle();
      write_limits(n_len, n_rnd, n_sqr, n_crl);

      phase_start = sent_chars;
      while (sent_chars - phase_start < 250) begin
        make_expr();
        send_expr();
      end
    end

    chars_if.valid <= 1'b0;
    settle();
    repeat (8) @(posedge clk);

    $display("sent %0d characters in %0d expressions over %0d limit settings",
             sent_chars, sent_exprs, limit_sets);
    $display("checked %0d verdicts (%0d valid), %0d mismatches",
             checked, judged_ok, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
